// ===== design/mws_pkg.sv =====
// Shared types, codes and constants of the multilink window scheduler.
package mws_pkg;

  // Widths fixed by the word format and the link state
  localparam int WIN_W      = 16;
  localparam int IFL_W      = 10;
  localparam int SEQ_W      = 31;
  localparam int ENTRY_W    = 32;
  localparam int TIME_W     = 32;
  localparam int TMO_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int ACTION_W   = 3;
  localparam int CHOSEN_W   = 2;
  localparam int LINK_IN_W  = 2;
  // Step counter, wide enough for the deepest log plus one
  localparam int CNT_W      = 11;
  // Restoring divider: one quotient bit per step
  localparam int DIV_STEPS  = WIN_W;
  localparam int PROD_W     = 20;
  localparam int WINDOW_SCALE = 1000;
  localparam logic [IFL_W-1:0] IFL_MAX = '1;

  // Reset values of the configuration registers
  localparam logic [WIN_W-1:0] RST_WINDOW_START   = 16'd20000;
  localparam logic [WIN_W-1:0] RST_WINDOW_FLOOR   = 16'd1000;
  localparam logic [WIN_W-1:0] RST_WINDOW_CAP     = 16'd60000;
  localparam logic [WIN_W-1:0] RST_LOSS_DECREMENT = 16'd100;
  localparam logic [WIN_W-1:0] RST_ACK_INCREMENT  = 16'd30;
  localparam logic [TMO_W-1:0] RST_TIMEOUT        = 8'd4;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_START   = 3'd0,
    CFG_WINDOW_FLOOR   = 3'd1,
    CFG_WINDOW_CAP     = 3'd2,
    CFG_LOSS_DECREMENT = 3'd3,
    CFG_ACK_INCREMENT  = 3'd4,
    CFG_TIMEOUT        = 3'd5
  } cfg_reg_t;

  // Input word action codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_SELECT  = 3'd0,
    ACT_RECORD  = 3'd1,
    ACT_NAK     = 3'd2,
    ACT_ACK     = 3'd3,
    ACT_CUM_ACK = 3'd4,
    ACT_RECV    = 3'd5,
    ACT_FAIL    = 3'd6,
    ACT_TICK    = 3'd7
  } action_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_PICK,
    ST_SEARCH,
    ST_DRAIN,
    ST_NAK,
    ST_ACK_CMP,
    ST_ACK_APPLY,
    ST_CUM,
    ST_TICK,
    ST_TICK_CLR,
    ST_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic             load;       // input word accepted this cycle
    logic             record;     // log the sent sequence
    logic             recv;       // receive time update
    logic             fail;       // send failure mark
    logic             clear;      // empty log slot cnt
    logic             clr_all;    // clear every link, not just the tick mask
    logic             srch_rd;    // read log slot for search step cnt
    logic             cum;        // search is a cumulative ack
    logic             div_step;   // one divider step on every link
    logic             pick_step;  // compare score of link cnt
    logic             nak_apply;
    logic             ack_cmp;
    logic             ack_apply;
    logic             cum_done;
    logic             tick_apply;
    logic             res_load;   // move result into output register
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_free;
    logic out_valid;
  } status_t;

endpackage

// ===== design/multilink_window_scheduler.sv =====
// Multilink window scheduler: picks a link per packet and tracks per-link windows and logs.
// Select runs a 16-step divider on all links, then compares one link per cycle; record,
// receive and send-failed update link state directly; NAK, cumulative ack and link ack
// search the logs one slot per cycle, all links in parallel; tick clears the timed-out
// logs in a sweep. One item at a time. Reset is synchronous; afterwards a clearing pass
// empties the logs, with input stalled. LOG_DEPTH must be a power of two.
module multilink_window_scheduler import mws_pkg::*; #(
  parameter int NUM_LINKS = 4,
  parameter int LOG_DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ACTION_W-1:0]   action,
  input  logic [LINK_IN_W-1:0]  link,
  input  logic [SEQ_W-1:0]      seq,
  input  logic [TIME_W-1:0]     now_seconds,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CHOSEN_W-1:0]   chosen_link,
  output logic                  link_valid,
  output logic                  found,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  mws_ctrl #(.NUM_LINKS(NUM_LINKS), .LOG_DEPTH(LOG_DEPTH)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .action   (action),
    .status   (status),
    .cmd      (cmd)
  );

  mws_datapath #(.NUM_LINKS(NUM_LINKS), .LOG_DEPTH(LOG_DEPTH)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .link        (link),
    .seq         (seq),
    .now_seconds (now_seconds),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .chosen_link (chosen_link),
    .link_valid  (link_valid),
    .found       (found)
  );

endmodule

// ===== design/mws_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/mws_ctrl.sv =====
// Controller state machine of the multilink window scheduler.
module mws_ctrl import mws_pkg::*; #(
  parameter int NUM_LINKS = 4,
  parameter int LOG_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ACTION_W-1:0] action,
  input  status_t             status,
  output cmd_t                cmd
);

  localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(LOG_DEPTH - 1);
  localparam logic [CNT_W-1:0] LAST_DIV  = CNT_W'(DIV_STEPS - 1);
  localparam logic [CNT_W-1:0] LAST_LINK = CNT_W'(NUM_LINKS - 1);

  state_t           state, state_next;
  action_t          act, act_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  // State, action and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      act   <= ACT_SELECT;
      cnt   <= '0;
    end else begin
      state <= state_next;
      act   <= act_next;
      cnt   <= cnt_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    act_next   = act;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.cnt    = cnt;
    cmd.cum    = (act == ACT_CUM_ACK);
    case (state)
      ST_CLEAR: begin
        cmd.clear   = 1'b1;
        cmd.clr_all = 1'b1;
        cnt_next    = cnt + 1'b1;
        if (cnt == LAST_SLOT) begin
          state_next = ST_IDLE;
          cnt_next   = '0;
        end
      end
      ST_IDLE: begin
        cnt_next = '0;
        if (in_valid) begin
          cmd.load = 1'b1;
          act_next = action_t'(action);
          case (action_t'(action))
            ACT_SELECT: state_next = ST_DIV;
            ACT_RECORD: begin
              cmd.record = 1'b1;
              state_next = ST_DONE;
            end
            ACT_NAK, ACT_ACK, ACT_CUM_ACK: begin
              state_next = ST_SEARCH;
              cnt_next   = CNT_W'(1);
            end
            ACT_RECV: begin
              cmd.recv   = 1'b1;
              state_next = ST_DONE;
            end
            ACT_FAIL: begin
              cmd.fail   = 1'b1;
              state_next = ST_DONE;
            end
            default: state_next = ST_TICK;
          endcase
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == LAST_DIV) begin
          state_next = ST_PICK;
          cnt_next   = '0;
        end
      end
      ST_PICK: begin
        cmd.pick_step = 1'b1;
        cnt_next      = cnt + 1'b1;
        if (cnt == LAST_LINK) begin
          state_next = ST_DONE;
        end
      end
      ST_SEARCH: begin
        cmd.srch_rd = 1'b1;
        cnt_next    = cnt + 1'b1;
        if (cnt == LAST_SLOT) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last read word is compared in this cycle
        case (act)
          ACT_NAK: state_next = ST_NAK;
          ACT_ACK: state_next = ST_ACK_CMP;
          default: state_next = ST_CUM;
        endcase
      end
      ST_NAK: begin
        cmd.nak_apply = 1'b1;
        state_next    = ST_DONE;
      end
      ST_ACK_CMP: begin
        cmd.ack_cmp = 1'b1;
        state_next  = ST_ACK_APPLY;
      end
      ST_ACK_APPLY: begin
        cmd.ack_apply = 1'b1;
        state_next    = ST_DONE;
      end
      ST_CUM: begin
        cmd.cum_done = 1'b1;
        state_next   = ST_DONE;
      end
      ST_TICK: begin
        cmd.tick_apply = 1'b1;
        state_next     = ST_TICK_CLR;
        cnt_next       = '0;
      end
      ST_TICK_CLR: begin
        cmd.clear = 1'b1;
        cnt_next  = cnt + 1'b1;
        if (cnt == LAST_SLOT) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // A result is only handed over when the output register can take it
  a_res_free: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |=> status.out_valid)
    else $error("result load did not reach the output register");

  // Clearing sweep and log search never run together
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cmd.clear && cmd.srch_rd))
    else $error("log clear overlaps search");

  // Leaving reset always starts the clearing pass
  a_reset_clear: assert property (@(posedge clk)
    $fell(rst) |-> state == ST_CLEAR)
    else $error("clearing pass skipped after reset");

endmodule

// ===== design/mws_datapath.sv =====
// Datapath: link state, per-link sent logs, dividers, search and result register.
module mws_datapath import mws_pkg::*; #(
  parameter int NUM_LINKS = 4,
  parameter int LOG_DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output status_t               status,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [LINK_IN_W-1:0]  link,
  input  logic [SEQ_W-1:0]      seq,
  input  logic [TIME_W-1:0]     now_seconds,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CHOSEN_W-1:0]   chosen_link,
  output logic                  link_valid,
  output logic                  found
);

  localparam int AW  = $clog2(LOG_DEPTH);
  localparam int LW  = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;
  localparam int DVW = IFL_W + 1;
  localparam int RMW = DVW + 1;
  localparam int SWW = WIN_W + 3;

  // Configuration registers (start window only matters at reset)
  logic [WIN_W-1:0] window_floor, window_cap, loss_decrement, ack_increment;
  logic [TMO_W-1:0] timeout_seconds;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_floor    <= RST_WINDOW_FLOOR;
      window_cap      <= RST_WINDOW_CAP;
      loss_decrement  <= RST_LOSS_DECREMENT;
      ack_increment   <= RST_ACK_INCREMENT;
      timeout_seconds <= RST_TIMEOUT;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        CFG_WINDOW_FLOOR:   window_floor    <= cfg_data;
        CFG_WINDOW_CAP:     window_cap      <= cfg_data;
        CFG_LOSS_DECREMENT: loss_decrement  <= cfg_data;
        CFG_ACK_INCREMENT:  ack_increment   <= cfg_data;
        CFG_TIMEOUT:        timeout_seconds <= cfg_data[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  // Per-link state
  logic [WIN_W-1:0]  win  [NUM_LINKS];
  logic [IFL_W-1:0]  ifl  [NUM_LINKS];
  logic [TIME_W-1:0] last [NUM_LINKS];
  logic [AW-1:0]     widx [NUM_LINKS];

  // Latched item fields
  logic [SEQ_W-1:0]  seq_r;
  logic [TIME_W-1:0] now_r;

  // Search pipeline and per-link match trackers
  logic              srch_v;
  logic [AW-1:0]     j_p;
  logic              m_found [NUM_LINKS];
  logic [AW-1:0]     m_slot  [NUM_LINKS];
  logic [AW-1:0]     cum_cnt [NUM_LINKS];
  logic [NUM_LINKS-1:0] clr_mask;

  // Dividers
  logic [WIN_W-1:0] dq  [NUM_LINKS];
  logic [RMW-1:0]   drm [NUM_LINKS];
  logic [DVW-1:0]   ddv [NUM_LINKS];

  // Selection and result
  logic [WIN_W-1:0] best;
  logic             best_v;
  logic [LW-1:0]    r_link;
  logic             r_valid, r_found;
  logic             grow_r;

  // RAM ports
  logic              ram_we    [NUM_LINKS];
  logic [AW-1:0]     ram_waddr [NUM_LINKS];
  logic [ENTRY_W-1:0] ram_wdata [NUM_LINKS];
  logic [AW-1:0]     ram_raddr [NUM_LINKS];
  logic [ENTRY_W-1:0] ram_rdata [NUM_LINKS];

  // Decoded input link
  logic          lk_ok;
  logic [LW-1:0] lk;
  assign lk_ok = (32'(link) < NUM_LINKS);
  assign lk    = LW'(link);

  // Timeout test per link against the latched time
  logic timed_out [NUM_LINKS];
  always_comb begin
    for (int k = 0; k < NUM_LINKS; k++) begin
      timed_out[k] = ({1'b0, last[k]} + 33'(timeout_seconds)) < {1'b0, now_r};
    end
  end

  // First matching link, lowest index wins
  logic          hit_any;
  logic [LW-1:0] hit_k;
  always_comb begin
    hit_any = 1'b0;
    hit_k   = '0;
    for (int k = NUM_LINKS - 1; k >= 0; k--) begin
      if (m_found[k]) begin
        hit_any = 1'b1;
        hit_k   = LW'(k);
      end
    end
  end

  // NAK window: max(window - decrement, floor)
  logic [WIN_W:0]   nak_diff;
  logic [WIN_W-1:0] nak_win;
  always_comb begin
    nak_diff = {1'b0, win[hit_k]} - {1'b0, loss_decrement};
    if (nak_diff[WIN_W] || nak_diff[WIN_W-1:0] < window_floor) begin
      nak_win = window_floor;
    end else begin
      nak_win = nak_diff[WIN_W-1:0];
    end
  end

  // Ack: decremented in-flight and growth test
  logic [IFL_W-1:0]  ack_dec;
  logic [PROD_W-1:0] ack_prod;
  always_comb begin
    ack_dec  = ifl[hit_k] - IFL_W'(ifl[hit_k] != '0);
    ack_prod = PROD_W'(ack_dec) * PROD_W'(WINDOW_SCALE);
  end

  // Ack: new window of every link
  logic [WIN_W-1:0] ack_win [NUM_LINKS];
  always_comb begin
    for (int k = 0; k < NUM_LINKS; k++) begin
      logic signed [SWW-1:0] w;
      w = $signed({3'b000, win[k]});
      if (hit_any && hit_k == LW'(k) && grow_r) begin
        w = w + $signed({3'b000, ack_increment}) - SWW'(1);
      end
      if (last[k] != '0) begin
        w = w + SWW'(1);
        if (w > $signed({3'b000, window_cap})) begin
          w = $signed({3'b000, window_cap});
        end
      end
      if (w < 0) begin
        ack_win[k] = '0;
      end else if (w > $signed({3'b000, {WIN_W{1'b1}}})) begin
        ack_win[k] = '1;
      end else begin
        ack_win[k] = w[WIN_W-1:0];
      end
    end
  end

  // Log write and read port selection
  always_comb begin
    for (int k = 0; k < NUM_LINKS; k++) begin
      ram_we[k]    = 1'b0;
      ram_waddr[k] = cmd.cnt[AW-1:0];
      ram_wdata[k] = '0;
      ram_raddr[k] = widx[k] - cmd.cnt[AW-1:0];
      if (cmd.clear) begin
        ram_we[k] = cmd.clr_all || clr_mask[k];
      end else if (cmd.record) begin
        ram_we[k]    = lk_ok && (lk == LW'(k));
        ram_waddr[k] = widx[k];
        ram_wdata[k] = {1'b1, seq};
      end else if (srch_v && cmd.cum) begin
        ram_waddr[k] = widx[k] - j_p;
        ram_we[k]    = ram_rdata[k][ENTRY_W-1] && (ram_rdata[k][SEQ_W-1:0] < seq_r);
      end else if ((cmd.nak_apply || cmd.ack_cmp) && hit_any) begin
        ram_waddr[k] = m_slot[k];
        ram_we[k]    = (hit_k == LW'(k));
      end
    end
  end

  // One log per link
  for (genvar g = 0; g < NUM_LINKS; g++) begin : g_log
    mws_ram #(.WIDTH(ENTRY_W), .DEPTH(LOG_DEPTH)) u_log (
      .clk     (clk),
      .wr_en   (ram_we[g]),
      .wr_addr (ram_waddr[g]),
      .wr_data (ram_wdata[g]),
      .rd_addr (ram_raddr[g]),
      .rd_data (ram_rdata[g])
    );
  end

  // Link state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_LINKS; k++) begin
        win[k]  <= RST_WINDOW_START;
        ifl[k]  <= '0;
        last[k] <= '0;
        widx[k] <= '0;
      end
      clr_mask <= '0;
    end else begin
      if (cmd.record && lk_ok) begin
        widx[lk] <= widx[lk] + 1'b1;
        if (ifl[lk] != IFL_MAX) begin
          ifl[lk] <= ifl[lk] + 1'b1;
        end
      end
      if (cmd.recv && lk_ok) begin
        last[lk] <= now_seconds;
      end
      if (cmd.fail && lk_ok) begin
        last[lk] <= TIME_W'(1);
      end
      if (cmd.nak_apply && hit_any) begin
        win[hit_k] <= nak_win;
      end
      if (cmd.ack_cmp && hit_any) begin
        ifl[hit_k] <= ack_dec;
      end
      if (cmd.ack_apply) begin
        for (int k = 0; k < NUM_LINKS; k++) begin
          win[k] <= ack_win[k];
        end
      end
      if (cmd.cum_done) begin
        for (int k = 0; k < NUM_LINKS; k++) begin
          ifl[k] <= IFL_W'(cum_cnt[k]);
        end
      end
      if (cmd.tick_apply) begin
        for (int k = 0; k < NUM_LINKS; k++) begin
          clr_mask[k] <= timed_out[k] && (last[k] != '0);
          if (timed_out[k] && (last[k] != '0)) begin
            last[k] <= '0;
            win[k]  <= window_floor;
            ifl[k]  <= '0;
          end
        end
      end
    end
  end

  // Item latch, search compare, dividers and selection
  always_ff @(posedge clk) begin
    if (rst) begin
      srch_v <= 1'b0;
    end else begin
      srch_v <= cmd.srch_rd;
    end
    j_p <= cmd.cnt[AW-1:0];
    if (cmd.ack_cmp) begin
      grow_r <= ack_prod > PROD_W'(win[hit_k]);
    end
    if (cmd.load) begin
      seq_r  <= seq;
      now_r  <= now_seconds;
      best   <= '0;
      best_v <= 1'b0;
      for (int k = 0; k < NUM_LINKS; k++) begin
        m_found[k] <= 1'b0;
        m_slot[k]  <= '0;
        cum_cnt[k] <= '0;
        dq[k]      <= win[k];
        drm[k]     <= '0;
        ddv[k]     <= DVW'(ifl[k]) + 1'b1;
      end
    end else begin
      if (srch_v) begin
        for (int k = 0; k < NUM_LINKS; k++) begin
          if (cmd.cum) begin
            if (ram_rdata[k][ENTRY_W-1] && !(ram_rdata[k][SEQ_W-1:0] < seq_r)) begin
              cum_cnt[k] <= cum_cnt[k] + 1'b1;
            end
          end else if (!m_found[k] && ram_rdata[k] == {1'b1, seq_r}) begin
            m_found[k] <= 1'b1;
            m_slot[k]  <= widx[k] - j_p;
          end
        end
      end
      if (cmd.div_step) begin
        for (int k = 0; k < NUM_LINKS; k++) begin
          logic [RMW-1:0] t;
          t = {drm[k][RMW-2:0], dq[k][WIN_W-1]};
          if (t >= RMW'(ddv[k])) begin
            drm[k] <= t - RMW'(ddv[k]);
            dq[k]  <= {dq[k][WIN_W-2:0], 1'b1};
          end else begin
            drm[k] <= t;
            dq[k]  <= {dq[k][WIN_W-2:0], 1'b0};
          end
        end
      end
      if (cmd.pick_step) begin
        if (!timed_out[cmd.cnt[LW-1:0]] && (!best_v || dq[cmd.cnt[LW-1:0]] > best)) begin
          best   <= dq[cmd.cnt[LW-1:0]];
          best_v <= 1'b1;
        end
      end
    end
  end

  // Result of the current item
  always_ff @(posedge clk) begin
    if (rst) begin
      r_link  <= '0;
      r_valid <= 1'b0;
      r_found <= 1'b0;
    end else if (cmd.load) begin
      r_link  <= '0;
      r_valid <= 1'b0;
      r_found <= 1'b0;
    end else if (cmd.pick_step) begin
      if (!timed_out[cmd.cnt[LW-1:0]] && (!best_v || dq[cmd.cnt[LW-1:0]] > best)) begin
        r_link  <= cmd.cnt[LW-1:0];
        r_valid <= 1'b1;
      end
    end else if ((cmd.nak_apply || cmd.ack_cmp) && hit_any) begin
      r_link  <= hit_k;
      r_valid <= 1'b1;
      r_found <= 1'b1;
    end
  end

  // Output register
  logic [LW+CHOSEN_W-1:0] r_link_ext;
  assign r_link_ext = (LW + CHOSEN_W)'(r_link);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.res_load) begin
      chosen_link <= r_link_ext[CHOSEN_W-1:0];
      link_valid  <= r_valid;
      found       <= r_found;
    end
  end

  assign status.out_free  = !out_valid || !out_stall;
  assign status.out_valid = out_valid;

  // A match always names a link
  a_found_valid: assert property (@(posedge clk) disable iff (rst)
    r_found |-> r_valid)
    else $error("match without a link");

  // The link that takes a match had its own search hit
  a_hit_link: assert property (@(posedge clk) disable iff (rst)
    ((cmd.nak_apply || cmd.ack_cmp) && hit_any) |-> m_found[hit_k])
    else $error("matched link has no search hit");

  // The search compare comes in the cycle after its read
  a_srch_pipe: assert property (@(posedge clk) disable iff (rst)
    cmd.srch_rd |=> srch_v)
    else $error("search compare stage lost a read");

endmodule

// ===== dv/multilink_window_scheduler_test.sv =====
// Self-checking testbench for the multilink window scheduler: directed table, then random traffic.
`timescale 1ns / 100ps

module multilink_window_scheduler_test;
  import mws_pkg::*;

  localparam int NLINK = 4;
  localparam int DEPTH = 256;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 1530;

  logic clk, rst;
  logic in_valid, in_stall;
  logic [ACTION_W-1:0] action;
  logic [LINK_IN_W-1:0] link;
  logic [SEQ_W-1:0] seq;
  logic [TIME_W-1:0] now_seconds;
  logic out_valid, out_stall;
  logic [CHOSEN_W-1:0] chosen_link;
  logic link_valid, found;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  multilink_window_scheduler #(.NUM_LINKS(NLINK), .LOG_DEPTH(DEPTH)) u_top (.*);

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  typedef struct packed {
    logic [CHOSEN_W-1:0] chosen;
    logic                lvalid;
    logic                fnd;
  } verdict_t;

  // Shadow of the scheduler state
  logic [WIN_W-1:0]  sh_start, sh_floor, sh_cap, sh_loss, sh_inc;
  logic [TMO_W-1:0]  sh_tmo;
  logic [WIN_W-1:0]  sh_win [NLINK];
  logic [IFL_W-1:0]  sh_ifl [NLINK];
  logic [TIME_W-1:0] sh_rx  [NLINK];
  logic [ENTRY_W-1:0] sh_log [NLINK][DEPTH];
  logic [7:0]        sh_wr  [NLINK];

  verdict_t verdicts_due[$];
  int errors, n_sent, n_got, n_found, n_cfg;
  int idle_cycles;
  bit stim_done;

  function automatic bit is_stale(int k, logic [TIME_W-1:0] now);
    return ({32'd0, sh_rx[k]} + sh_tmo) < {32'd0, now};
  endfunction

  function automatic void shadow_reset();
    sh_start = RST_WINDOW_START; sh_floor = RST_WINDOW_FLOOR; sh_cap = RST_WINDOW_CAP;
    sh_loss = RST_LOSS_DECREMENT; sh_inc = RST_ACK_INCREMENT; sh_tmo = RST_TIMEOUT;
    for (int k = 0; k < NLINK; k++) begin
      sh_win[k] = sh_start; sh_ifl[k] = '0; sh_rx[k] = '0; sh_wr[k] = '0;
      for (int s = 0; s < DEPTH; s++) sh_log[k][s] = '0;
    end
  endfunction

  function automatic void shadow_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      CFG_WINDOW_START:   sh_start = d;
      CFG_WINDOW_FLOOR:   sh_floor = d;
      CFG_WINDOW_CAP:     sh_cap = d;
      CFG_LOSS_DECREMENT: sh_loss = d;
      CFG_ACK_INCREMENT:  sh_inc = d;
      CFG_TIMEOUT:        sh_tmo = d[TMO_W-1:0];
      default: ;
    endcase
  endfunction

  // Predict the result of one word and advance the shadow state
  function automatic verdict_t schedule_word(action_t a, logic [1:0] lk,
                                             logic [SEQ_W-1:0] sq, logic [TIME_W-1:0] now);
    verdict_t v;
    longint best, score, w;
    int s, cnt;
    logic [ENTRY_W-1:0] key;
    v = '0;
    key = {1'b1, sq};
    case (a)
      ACT_SELECT: begin
        best = -1;
        for (int k = 0; k < NLINK; k++) begin
          if (is_stale(k, now)) continue;
          score = sh_win[k] / (sh_ifl[k] + 1);
          if (score > best) begin
            best = score; v.chosen = CHOSEN_W'(k); v.lvalid = 1'b1;
          end
        end
      end
      ACT_RECORD: begin
        sh_log[lk][sh_wr[lk]] = key;
        sh_wr[lk] = sh_wr[lk] + 8'd1;
        if (sh_ifl[lk] != IFL_MAX) sh_ifl[lk]++;
      end
      ACT_NAK: begin
        for (int k = 0; k < NLINK && !v.fnd; k++)
          for (int j = 1; j < DEPTH; j++) begin
            s = (sh_wr[k] + DEPTH - j) % DEPTH;
            if (sh_log[k][s] == key) begin
              w = longint'(sh_win[k]) - longint'(sh_loss);
              if (w < longint'(sh_floor)) w = longint'(sh_floor);
              sh_win[k] = w[15:0];
              sh_log[k][s] = '0;
              v.fnd = 1'b1; v.lvalid = 1'b1; v.chosen = CHOSEN_W'(k);
              break;
            end
          end
      end
      ACT_ACK: begin
        for (int k = 0; k < NLINK; k++) begin
          w = sh_win[k];
          for (int j = 1; j < DEPTH && !v.fnd; j++) begin
            s = (sh_wr[k] + DEPTH - j) % DEPTH;
            if (sh_log[k][s] == key) begin
              v.fnd = 1'b1; v.lvalid = 1'b1; v.chosen = CHOSEN_W'(k);
              if (sh_ifl[k] != 0) sh_ifl[k]--;
              sh_log[k][s] = '0;
              if (longint'(sh_ifl[k]) * WINDOW_SCALE > w) w += longint'(sh_inc) - 1;
              break;
            end
          end
          if (sh_rx[k] != 0) begin
            w += 1;
            if (w > longint'(sh_cap)) w = longint'(sh_cap);
          end
          if (w < 0) w = 0;
          if (w > 65535) w = 65535;
          sh_win[k] = w[15:0];
        end
      end
      ACT_CUM_ACK: begin
        for (int k = 0; k < NLINK; k++) begin
          cnt = 0;
          for (int j = 1; j < DEPTH; j++) begin
            s = (sh_wr[k] + DEPTH - j) % DEPTH;
            if (!sh_log[k][s][31]) continue;
            if (sh_log[k][s][30:0] < sq) sh_log[k][s] = '0;
            else cnt++;
          end
          sh_ifl[k] = (cnt > 1023) ? IFL_MAX : IFL_W'(cnt);
        end
      end
      ACT_RECV: sh_rx[lk] = now;
      ACT_FAIL: sh_rx[lk] = 32'd1;
      default: begin
        for (int k = 0; k < NLINK; k++)
          if (is_stale(k, now) && sh_rx[k] > 0) begin
            sh_rx[k] = '0; sh_win[k] = sh_floor; sh_ifl[k] = '0;
            for (int q = 0; q < DEPTH; q++) sh_log[k][q] = '0;
          end
      end
    endcase
    return v;
  endfunction

  // Directed table; chk marks rows whose result is typed in
  typedef struct {
    action_t a; logic [1:0] lk; logic [SEQ_W-1:0] sq; logic [TIME_W-1:0] now;
    bit chk; verdict_t v;
  } dir_row_t;

  dir_row_t dir_rows[$];
  logic [SEQ_W-1:0] recent_seq[$];

  function automatic void add_row(action_t a, logic [1:0] lk, logic [SEQ_W-1:0] sq,
                                  logic [TIME_W-1:0] now, bit chk, verdict_t v);
    dir_row_t r;
    r.a = a; r.lk = lk; r.sq = sq; r.now = now; r.chk = chk; r.v = v;
    dir_rows.push_back(r);
  endfunction

  // Send one word and queue its expectation
  task automatic send_word(action_t a, logic [1:0] lk, logic [SEQ_W-1:0] sq,
                           logic [TIME_W-1:0] now, bit chk, verdict_t typed);
    verdict_t v;
    v = schedule_word(a, lk, sq, now);
    if (chk && v !== typed) begin
      $display("%0t: table row mismatch, typed %p predicted %p", $time, typed, v);
      errors++;
    end
    verdicts_due.push_back(v);
    if (a == ACT_RECORD) begin
      recent_seq.push_back(sq);
      if (recent_seq.size() > 64) void'(recent_seq.pop_front());
    end
    in_valid <= 1'b1;
    action <= a; link <= lk; seq <= sq; now_seconds <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
  endtask

  // Burst shaping on the sender
  int burst_left;
  task automatic sender_gap();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic drain_and_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    cfg_write <= 1'b1; cfg_index <= idx; cfg_data <= d;
    @(posedge clk);
    cfg_write <= 1'b0;
    shadow_cfg(idx, d);
    n_cfg++;
  endtask

  // Receiver stall pattern
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else case (($time / 12) % 97 < 30 ? 0 : $urandom_range(0, 3))
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 4) == 0);
    endcase
  end

  // Result checker and watchdog
  always @(posedge clk) begin
    verdict_t exp_v;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
      if (out_valid && !out_stall) begin
        n_got++;
        if (verdicts_due.size() == 0) begin
          $display("%0t: unexpected word chosen=%0d valid=%0d found=%0d", $time,
                   chosen_link, link_valid, found);
          errors++;
        end else begin
          exp_v = verdicts_due.pop_front();
          if (found) n_found++;
          if (chosen_link !== exp_v.chosen)
            begin $display("%0t: chosen_link exp %0d got %0d", $time, exp_v.chosen,
                           chosen_link); errors++; end
          if (link_valid !== exp_v.lvalid)
            begin $display("%0t: link_valid exp %0d got %0d", $time, exp_v.lvalid,
                           link_valid); errors++; end
          if (found !== exp_v.fnd)
            begin $display("%0t: found exp %0d got %0d", $time, exp_v.fnd, found);
                  errors++; end
        end
      end
    end
  end

  // Main sequence
  initial begin
    action_t a;
    logic [SEQ_W-1:0] sq;
    logic [TIME_W-1:0] now, clock_s;
    int pick, wait_n;
    rst = 1'b1; in_valid = 1'b0; action = ACT_SELECT; link = '0; seq = '0;
    now_seconds = '0; cfg_write = 1'b0; cfg_index = '0; cfg_data = '0;
    errors = 0; n_sent = 0; n_got = 0; n_found = 0; n_cfg = 0; idle_cycles = 0;
    burst_left = 0; stim_done = 0;
    shadow_reset();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: after reset, records at extremes, nak/ack hits and misses
    add_row(ACT_SELECT, 0, 0, 0, 1, '{0, 1, 0});
    add_row(ACT_SELECT, 0, 0, 32'hFFFF_FFFF, 1, '{0, 0, 0});
    add_row(ACT_RECORD, 0, 31'h7FFF_FFFF, 0, 1, '0);
    add_row(ACT_RECORD, 1, 0, 0, 1, '0);
    add_row(ACT_RECORD, 3, 31'h5555_5555, 0, 1, '0);
    add_row(ACT_RECORD, 2, 31'h2AAA_AAAA, 0, 1, '0);
    add_row(ACT_SELECT, 0, 0, 2, 0, '0);
    add_row(ACT_NAK, 0, 31'h7FFF_FFFF, 0, 1, '{0, 1, 1});
    add_row(ACT_NAK, 0, 31'h7FFF_FFFF, 0, 1, '{0, 0, 0});
    add_row(ACT_RECV, 1, 0, 32'hFFFF_FFFF, 1, '0);
    add_row(ACT_FAIL, 2, 0, 0, 1, '0);
    add_row(ACT_ACK, 0, 0, 0, 1, '{1, 1, 1});
    add_row(ACT_ACK, 0, 31'h1234, 0, 1, '{0, 0, 0});
    add_row(ACT_RECORD, 3, 31'h10, 0, 1, '0);
    add_row(ACT_CUM_ACK, 0, 31'h11, 0, 1, '0);
    add_row(ACT_SELECT, 0, 0, 3, 0, '0);
    add_row(ACT_TICK, 0, 0, 32'd100, 1, '0);
    add_row(ACT_SELECT, 0, 0, 32'd100, 0, '0);
    add_row(ACT_ACK, 0, 31'h5555_5555, 0, 0, '0);
    add_row(ACT_TICK, 0, 0, 32'hFFFF_FFFF, 1, '0);
    add_row(ACT_SELECT, 0, 0, 0, 0, '0);
    foreach (dir_rows[i]) begin
      sender_gap();
      send_word(dir_rows[i].a, dir_rows[i].lk, dir_rows[i].sq, dir_rows[i].now,
                dir_rows[i].chk, dir_rows[i].v);
    end

    // Random phases, each under its own register setting
    clock_s = 32'd10;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin drain_and_config(CFG_WINDOW_START, 16'hFFFF);
                 drain_and_config(CFG_TIMEOUT, 8'd255); end
        1: begin drain_and_config(CFG_WINDOW_FLOOR, 16'd0);
                 drain_and_config(CFG_LOSS_DECREMENT, 16'hFFFF);
                 drain_and_config(CFG_ACK_INCREMENT, 16'd1); end
        2: begin drain_and_config(CFG_WINDOW_CAP, 16'd0);
                 drain_and_config(CFG_TIMEOUT, 8'd0);
                 drain_and_config(CFG_WINDOW_START, 16'd0); end
        3: begin drain_and_config(CFG_WINDOW_CAP, 16'hFFFF);
                 drain_and_config(CFG_ACK_INCREMENT, 16'hFFFF);
                 drain_and_config(CFG_WINDOW_FLOOR, 16'hFFFF); end
        4: begin
          drain_and_config(CFG_WINDOW_FLOOR, CFG_DATA_W'($urandom_range(0, 5000)));
          drain_and_config(CFG_LOSS_DECREMENT, CFG_DATA_W'($urandom_range(0, 3000)));
          drain_and_config(CFG_TIMEOUT, CFG_DATA_W'($urandom_range(1, 20)));
          drain_and_config(3'd7, 16'hFFFF);
        end
        default: begin
          drain_and_config(CFG_WINDOW_START, RST_WINDOW_START);
          drain_and_config(CFG_WINDOW_FLOOR, RST_WINDOW_FLOOR);
          drain_and_config(CFG_WINDOW_CAP, RST_WINDOW_CAP);
          drain_and_config(CFG_LOSS_DECREMENT, RST_LOSS_DECREMENT);
          drain_and_config(CFG_ACK_INCREMENT, RST_ACK_INCREMENT);
          drain_and_config(CFG_TIMEOUT, RST_TIMEOUT);
        end
      endcase
      for (int i = 0; i < N_RANDOM / 6; i++) begin
        sender_gap();
        pick = $urandom_range(0, 99);
        clock_s = clock_s + $urandom_range(0, 2);
        now = ($urandom_range(0, 19) == 0) ? $urandom : clock_s;
        // Sequences mostly reuse recent ones so naks and acks hit
        if (recent_seq.size() != 0 && $urandom_range(0, 3) != 0)
          sq = recent_seq[$urandom_range(0, recent_seq.size() - 1)];
        else sq = SEQ_W'({$urandom} >> 1);
        if (pick < 30) a = ACT_RECORD;
        else if (pick < 50) a = ACT_SELECT;
        else if (pick < 62) a = ACT_NAK;
        else if (pick < 76) a = ACT_ACK;
        else if (pick < 80) a = ACT_CUM_ACK;
        else if (pick < 92) a = ACT_RECV;
        else if (pick < 95) a = ACT_FAIL;
        else a = ACT_TICK;
        if (a == ACT_RECORD) sq = ($urandom_range(0, 9) == 0) ? SEQ_W'({$urandom} >> 1)
                                   : SEQ_W'(clock_s[30:0] * 31'd7 + $urandom_range(0, 6));
        send_word(a, 2'($urandom_range(0, 3)), sq, now, 0, '0);
      end
    end
    in_valid <= 1'b0;
    stim_done = 1;

    // Wait for the tail
    @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
    wait_n = DEPTH + 8;
    repeat (wait_n) @(posedge clk);
    $display("Ran %0d words (%0d found a logged sequence) across %0d register writes.",
             n_sent, n_found, n_cfg);
    $display("Results checked: %0d, mismatches: %0d.", n_got, errors);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
